>>> rtl/sliding_window_min_max_mean_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window min / max / mean block
// Short forms for clocked implications with a synchronous reset as disable.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH

// same-cycle implication
`define SWMM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swmm: same-cycle check failed");

// next-cycle implication
`define SWMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swmm: next-cycle check failed");

`endif

>>> rtl/swmm_pkg.sv
// ---------------------------------------------------------------------------
// swmm_pkg
// Shared widths, register map, controller states and command/status types.
// ---------------------------------------------------------------------------
package swmm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int HIGH_W         = 15;
  localparam int LEN_REG_W      = 8;
  localparam int WINDOW_MAX_DEF = 128;
  localparam int WIN_LEN_MIN    = 2;

  localparam logic [LEN_REG_W-1:0] WIN_LEN_RESET = 8'd60;

  // APB map: one 32-bit register per word, index taken from paddr[2]
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_IDX_WINDOW_LEN = 1'b0;

  localparam int OUT_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_LAST,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // take the new sample, latch window length, clear stats
    logic step;       // advance the window sweep by one entry
    logic put_new;    // store the new sample at the window end
    logic div_start;  // launch the mean division
    logic out_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic shift_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/swmm_ram.sv
// ---------------------------------------------------------------------------
// swmm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module swmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/swmm_div.sv
// ---------------------------------------------------------------------------
// swmm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module swmm_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign shifted = {rem, quotient[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= CNT_W'(DVD_W);
    end else if (busy) begin
      rem      <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
      cnt      <= cnt - CNT_W'(1);
    end
  end

endmodule

>>> rtl/swmm_dp.sv
// ---------------------------------------------------------------------------
// swmm_dp
// Window memory sweep, running min/max/sum, mean divider and result register.
// ---------------------------------------------------------------------------
module swmm_dp #(
  parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  swmm_pkg::cmd_t                   cmd,
  output swmm_pkg::stat_t                  stat,
  input  logic [swmm_pkg::LEN_REG_W-1:0]   window_len,
  input  logic [swmm_pkg::SAMPLE_W-1:0]    sample,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [swmm_pkg::OUT_W-1:0]       m_tdata
);

  localparam int ADDR_W = $clog2(WINDOW_MAX);
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = swmm_pkg::SAMPLE_W + LEN_W;
  localparam int SW     = swmm_pkg::SAMPLE_W;

  logic [SW-1:0]           sample_q;
  logic [LEN_W-1:0]        n_q;
  logic [LEN_W-1:0]        n_eff;
  logic [LEN_W-1:0]        rd_addr;
  logic [LEN_W-1:0]        rd_addr_m1;
  logic [LEN_W-1:0]        last_idx;
  logic                    p_valid;
  logic [ADDR_W-1:0]       p_waddr;
  logic [LEN_W-1:0]        fill;
  logic                    rd_vld_q;
  logic signed [SW-1:0]    lo;
  logic signed [SW-1:0]    hi;
  logic signed [SUM_W-1:0] sum;
  logic                    neg_q;
  logic                    issue;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;
  logic [SW-1:0]           ram_rdata;
  logic [SW-1:0]           rd_word;
  logic signed [SW-1:0]    fold_v;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        quo;
  logic [SUM_W-1:0]        quo_signed;
  logic                    div_done;

  // clamp the configured length into 2..WINDOW_MAX
  always_comb begin
    if (int'(window_len) < swmm_pkg::WIN_LEN_MIN) begin
      n_eff = LEN_W'(swmm_pkg::WIN_LEN_MIN);
    end else if (int'(window_len) > WINDOW_MAX) begin
      n_eff = LEN_W'(WINDOW_MAX);
    end else begin
      n_eff = LEN_W'(window_len);
    end
  end

  assign issue      = cmd.step && (rd_addr < n_q);
  assign rd_addr_m1 = rd_addr - LEN_W'(1);
  assign last_idx   = n_q - LEN_W'(1);
  assign raddr      = rd_addr[ADDR_W-1:0];
  assign rd_word    = rd_vld_q ? ram_rdata : '0;

  assign we     = (cmd.step && p_valid) || cmd.put_new;
  assign waddr  = cmd.put_new ? last_idx[ADDR_W-1:0] : p_waddr;
  assign fold_v = cmd.put_new ? $signed(sample_q) : $signed(rd_word);

  swmm_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (fold_v),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // entries never written read as zero: every sample writes entries 0..N-1,
  // so the written part is always the prefix below the largest N used
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.put_new && (n_q > fill)) begin
      fill <= n_q;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_q <= (rd_addr < fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (cmd.load) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= sample;
      n_q      <= n_eff;
      rd_addr  <= LEN_W'(1);
      lo       <= '0;
      hi       <= '0;
      sum      <= '0;
    end else begin
      if (issue) begin
        rd_addr <= rd_addr + LEN_W'(1);
        p_waddr <= rd_addr_m1[ADDR_W-1:0];
      end
      if (we) begin
        if (fold_v < lo) begin
          lo <= fold_v;
        end
        if (fold_v > hi) begin
          hi <= fold_v;
        end
        sum <= sum + SUM_W'(fold_v);
      end
    end
  end

  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_q <= sum[SUM_W-1];
    end
  end

  swmm_div #(
    .DVD_W (SUM_W),
    .DVS_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (n_q),
    .done     (div_done),
    .quotient (quo)
  );

  // truncate toward zero: divide the magnitude, restore the sign
  assign quo_signed = neg_q ? (~quo + SUM_W'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, quo_signed[SW-1:0], hi[swmm_pkg::HIGH_W-1:0], lo, sample_q};
    end
  end

  assign stat.shift_done = !(rd_addr < n_q) && !p_valid;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

>>> rtl/swmm_ctrl.sv
// ---------------------------------------------------------------------------
// swmm_ctrl
// Sequencer: accept, sweep the window, store the sample, divide, deliver.
// ---------------------------------------------------------------------------
module swmm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  swmm_pkg::stat_t stat,
  output swmm_pkg::cmd_t  cmd
);

  swmm_pkg::state_t state;
  swmm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swmm_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = swmm_pkg::ST_SHIFT;
        end
      end
      swmm_pkg::ST_SHIFT: begin
        if (stat.shift_done) begin
          state_next = swmm_pkg::ST_LAST;
        end
      end
      swmm_pkg::ST_LAST: begin
        state_next = swmm_pkg::ST_START;
      end
      swmm_pkg::ST_START: begin
        state_next = swmm_pkg::ST_DIV;
      end
      swmm_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = swmm_pkg::ST_OUT;
        end
      end
      swmm_pkg::ST_OUT: begin
        if (stat.out_free) begin
          state_next = swmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      swmm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      swmm_pkg::ST_SHIFT: begin
        cmd.step = 1'b1;
      end
      swmm_pkg::ST_LAST: begin
        cmd.put_new = 1'b1;
      end
      swmm_pkg::ST_START: begin
        cmd.div_start = 1'b1;
      end
      swmm_pkg::ST_DIV: begin
        cmd = '0;
      end
      swmm_pkg::ST_OUT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/sliding_window_min_max_mean.sv
// ---------------------------------------------------------------------------
// sliding_window_min_max_mean
// Sliding window minimum, maximum and truncated mean of signed samples.
// ---------------------------------------------------------------------------
// Each transfer on the input stream carries one signed 16-bit sample. The
// window is the last N samples, N being window_len clamped to 2..WINDOW_MAX
// (values 0 and 1 act as 2). Per sample the block shifts entries 1..N-1 of
// the window memory down by one place, stores the sample at entry N-1 and
// returns the sample, min and max of the window (both taken together with
// zero, so low_bound <= 0 <= high_bound) and the window sum divided by N,
// truncated toward zero. Entries at N and above keep their values and come
// back if N is raised later. The window memory reads as all zeros after
// reset through a fill mark (entries at and above the largest N used so far
// read as zero), so there is no clearing pass and the block takes a sample
// in the first cycle after reset. The block takes no new sample until
// the result of the last one is loaded into the output register: the
// sweep moves one entry per cycle through the single read and write port
// of the window memory, and the mean comes from a divider that yields one
// quotient bit per cycle over the SUM_W = 16 + clog2(WINDOW_MAX + 1) bit
// sum. A finished result waits in the output register while the next
// sample is taken. Write window_len only while no sample is in flight.
// ---------------------------------------------------------------------------
module sliding_window_min_max_mean #(
  parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swmm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [swmm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [swmm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  // sample stream in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [swmm_pkg::SAMPLE_W-1:0]     s_tdata,  // [15:0] sample
  // result stream out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [swmm_pkg::OUT_W-1:0]        m_tdata   // [15:0] newest, [31:16] low_bound,
                                                      // [46:32] high_bound, [62:47] mean,
                                                      // [63] zero
);

  logic [swmm_pkg::LEN_REG_W-1:0] window_len;
  logic                           reg_sel;
  swmm_pkg::cmd_t                 cmd;
  swmm_pkg::stat_t                stat;

  // register index is the word address; only word 0 exists
  assign reg_sel = (paddr[2] == swmm_pkg::REG_IDX_WINDOW_LEN);
  assign pready  = 1'b1;

  // write completes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swmm_pkg::WIN_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window_len <= pwdata[swmm_pkg::LEN_REG_W-1:0];
    end
  end

  assign prdata = reg_sel ? swmm_pkg::APB_DATA_W'(window_len) : '0;

  swmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swmm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .window_len (window_len),
    .sample     (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

>>> rtl/swmm_chk.sv
// ---------------------------------------------------------------------------
// swmm_chk
// Port-level checks for the sliding window block, bound to the top level.
// ---------------------------------------------------------------------------
`include "sliding_window_min_max_mean_macros.svh"

module swmm_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [swmm_pkg::OUT_W-1:0]  m_tdata
);

  logic signed [15:0] lo_v;
  logic signed [16:0] hi_v;
  logic signed [16:0] mean_v;
  logic               out_hold;
  logic               in_xfer;
  logic               range_ok;

  assign lo_v     = $signed(m_tdata[31:16]);
  assign hi_v     = $signed({2'b00, m_tdata[46:32]});
  assign mean_v   = $signed({m_tdata[62], m_tdata[62:47]});
  assign out_hold = m_tvalid && !m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign range_ok = (lo_v <= 16'sd0) && (mean_v >= 17'(lo_v)) && (mean_v <= hi_v);

  // a stalled result stays put
  `SWMM_ASSERT_NEXT(a_out_hold, clk, rst, out_hold, m_tvalid && $stable(m_tdata))
  // one sample at a time: no second accept right after a transfer
  `SWMM_ASSERT_NEXT(a_one_in_flight, clk, rst, in_xfer, !s_tready)
  // a new result only appears after the block was busy
  `SWMM_ASSERT_IMPLY(a_out_after_work, clk, rst, $rose(m_tvalid), $past(!s_tready))
  // mean lies between the bounds, and the low bound never exceeds zero
  `SWMM_ASSERT_IMPLY(a_mean_in_range, clk, rst, m_tvalid, range_ok)

endmodule

bind sliding_window_min_max_mean swmm_chk u_swmm_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
